@@ design/rsp_pkg.sv @@
// Shared types, constants and GF(2^8) arithmetic for the Reed-Solomon parity encoder.
// Used by every module of the encoder; depends on nothing else.
package rsp_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_W = 6;
	localparam logic [CFG_W-1:0] PARITY_RESET = 6'd10;
	localparam logic [BYTE_W-1:0] GF_REDUCE = 8'h1D;
	localparam logic [BYTE_W-1:0] GF_ONE = 8'h01;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} word_t;

	function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
		logic [BYTE_W-1:0] r;
		r = {a[BYTE_W-2:0], 1'b0};
		if (a[BYTE_W-1]) begin
			r = r ^ GF_REDUCE;
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] x;
		logic [BYTE_W-1:0] acc;
		x = a;
		acc = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

endpackage

@@ design/rsp_fifo.sv @@
// Two-entry word queue between the input handshake and the LFSR stage.
// Depends on rsp_pkg for the word type.
module rsp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rsp_pkg::word_t push_word,
	output logic          pop_valid,
	input  logic          pop_ready,
	output rsp_pkg::word_t pop_word
);

	rsp_pkg::word_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_word = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

@@ design/rsp_gen.sv @@
// Generator polynomial builder: multiplies in one factor (x + alpha^i) per cycle.
// Depends on rsp_pkg for GF(2^8) arithmetic.
module rsp_gen #(
	parameter int MAX_PARITY = 32,
	parameter int PW = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic [PW-1:0]              p_eff,
	output logic                       ready,
	output logic [rsp_pkg::BYTE_W-1:0] coef [MAX_PARITY]
);

	logic                       ready_q;
	logic                       busy_q;
	logic [PW-1:0]              step_q;
	logic [rsp_pkg::BYTE_W-1:0] root_q;
	logic [rsp_pkg::BYTE_W-1:0] poly_q [MAX_PARITY];
	logic [rsp_pkg::BYTE_W-1:0] poly_nxt [MAX_PARITY];
	logic                       start;

	assign start = !restart && !ready_q && !busy_q;
	assign ready = ready_q;
	assign coef = poly_q;

	always_comb begin
		poly_nxt[0] = rsp_pkg::gf_mul(root_q, poly_q[0]);
		for (int k = 1; k < MAX_PARITY; k++) begin
			poly_nxt[k] = poly_q[k-1] ^ rsp_pkg::gf_mul(root_q, poly_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			busy_q <= 1'b0;
			step_q <= '0;
			root_q <= rsp_pkg::GF_ONE;
		end else if (restart) begin
			ready_q <= 1'b0;
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			root_q <= rsp_pkg::GF_ONE;
		end else if (busy_q) begin
			root_q <= rsp_pkg::gf_xtime(root_q);
			step_q <= step_q + PW'(1);
			if (step_q + PW'(1) == p_eff) begin
				busy_q <= 1'b0;
				ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			poly_q[0] <= rsp_pkg::GF_ONE;
			for (int k = 1; k < MAX_PARITY; k++) begin
				poly_q[k] <= '0;
			end
		end else if (busy_q && !restart) begin
			poly_q <= poly_nxt;
		end
	end

endmodule

@@ design/rsp_lfsr.sv @@
// Remainder LFSR: takes queued words and updates the parity remainder once per word.
// Depends on rsp_pkg for the word type and GF(2^8) arithmetic.
module rsp_lfsr #(
	parameter int MAX_PARITY = 32,
	parameter int PW = 6,
	parameter int IW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic                       gen_ready,
	input  logic [rsp_pkg::BYTE_W-1:0] coef [MAX_PARITY],
	input  logic [PW-1:0]              p_eff,
	input  logic [IW-1:0]              top_idx,
	input  logic                       q_valid,
	input  rsp_pkg::word_t             q_word,
	output logic                       q_pop,
	input  logic                       load_ok,
	output logic                       load,
	output logic [rsp_pkg::BYTE_W-1:0] snap [MAX_PARITY]
);

	logic [rsp_pkg::BYTE_W-1:0] rem_q [MAX_PARITY];
	logic [rsp_pkg::BYTE_W-1:0] rem_nxt [MAX_PARITY];
	logic [rsp_pkg::BYTE_W-1:0] fb;

	assign q_pop = q_valid && gen_ready && (!q_word.last || load_ok);
	assign load = q_pop && q_word.last;
	assign fb = q_word.data ^ rem_q[top_idx];
	assign snap = rem_nxt;

	always_comb begin
		rem_nxt[0] = rsp_pkg::gf_mul(fb, coef[0]);
		for (int d = 1; d < MAX_PARITY; d++) begin
			if (PW'(d) < p_eff) begin
				rem_nxt[d] = rem_q[d-1] ^ rsp_pkg::gf_mul(fb, coef[d]);
			end else begin
				rem_nxt[d] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_PARITY; d++) begin
				rem_q[d] <= '0;
			end
		end else if (clear || load) begin
			for (int d = 0; d < MAX_PARITY; d++) begin
				rem_q[d] <= '0;
			end
		end else if (q_pop) begin
			rem_q <= rem_nxt;
		end
	end

endmodule

@@ design/rsp_unload.sv @@
// Parity unload register: holds one finished remainder and shifts it out word by word.
// Depends on rsp_pkg for the byte width.
module rsp_unload #(
	parameter int MAX_PARITY = 32,
	parameter int PW = 6,
	parameter int IW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [rsp_pkg::BYTE_W-1:0] snap [MAX_PARITY],
	input  logic [PW-1:0]              p_eff,
	input  logic [IW-1:0]              top_idx,
	output logic                       load_ok,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rsp_pkg::BYTE_W-1:0] parity_byte,
	output logic                       last_parity
);

	logic [rsp_pkg::BYTE_W-1:0] shift_q [MAX_PARITY];
	logic [PW-1:0]              count_q;
	logic                       fire;

	assign out_valid = (count_q != '0);
	assign fire = out_valid && out_ready;
	assign last_parity = (count_q == PW'(1));
	assign load_ok = !out_valid || (last_parity && out_ready);
	assign parity_byte = shift_q[top_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= p_eff;
		end else if (fire) begin
			count_q <= count_q - PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= snap;
		end else if (fire) begin
			shift_q[0] <= '0;
			for (int d = 1; d < MAX_PARITY; d++) begin
				shift_q[d] <= shift_q[d-1];
			end
		end
	end

endmodule

@@ design/reed_solomon_parity_encoder_core.sv @@
// Top level of the systematic Reed-Solomon parity encoder over GF(2^8), polynomial 0x11D.
// Depends on rsp_pkg, rsp_fifo, rsp_gen, rsp_lfsr and rsp_unload.
//
//   Channel  Handshake               Payload                     Direction
//   config   cfg_we                  cfg_wdata[5:0]              in
//   message  in_valid / in_ready     data_byte[7:0], last_data   in
//   parity   out_valid / out_ready   parity_byte[7:0], last_parity  out
//
// One message word is taken per cycle while the queue has room; the LFSR stage consumes
// one word per cycle while the generator is ready. A last word hands the remainder to the
// unload register, which sends p parity words while the next message already streams in;
// a second last word waits for it. After reset or a configuration write the generator is
// rebuilt: a start step, then one factor per cycle; words queue two deep, then in_ready drops.
// Reset clears the remainder, the queue, the unload count and sets the parity count to 10.
module reed_solomon_parity_encoder_core #(
	parameter int MAX_PARITY = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rsp_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rsp_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        last_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rsp_pkg::BYTE_W-1:0]  parity_byte,
	output logic                        last_parity
);

	localparam int PW = $clog2(MAX_PARITY + 1);
	localparam int IW = $clog2(MAX_PARITY);

	logic [rsp_pkg::CFG_W-1:0]  cfg_q;
	logic [7:0]                 p_wide;
	logic [PW-1:0]              p_eff;
	logic [PW-1:0]              p_top;
	logic [IW-1:0]              top_idx;
	rsp_pkg::word_t             in_word;
	rsp_pkg::word_t             q_word;
	logic                       q_valid;
	logic                       q_pop;
	logic                       gen_ready;
	logic [rsp_pkg::BYTE_W-1:0] coef [MAX_PARITY];
	logic [rsp_pkg::BYTE_W-1:0] snap [MAX_PARITY];
	logic                       load;
	logic                       load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rsp_pkg::PARITY_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_comb begin
		p_wide = {{(8 - rsp_pkg::CFG_W){1'b0}}, cfg_q};
		if (p_wide == 8'd0) begin
			p_wide = 8'd1;
		end else if (p_wide > 8'(MAX_PARITY)) begin
			p_wide = 8'(MAX_PARITY);
		end
	end

	assign p_eff = p_wide[PW-1:0];
	assign p_top = p_eff - PW'(1);
	assign top_idx = p_top[IW-1:0];

	assign in_word.data = data_byte;
	assign in_word.last = last_data;

	rsp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_word  (in_word),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_word   (q_word)
	);

	rsp_gen #(
		.MAX_PARITY (MAX_PARITY),
		.PW         (PW)
	) u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.p_eff   (p_eff),
		.ready   (gen_ready),
		.coef    (coef)
	);

	rsp_lfsr #(
		.MAX_PARITY (MAX_PARITY),
		.PW         (PW),
		.IW         (IW)
	) u_lfsr (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_we),
		.gen_ready (gen_ready),
		.coef      (coef),
		.p_eff     (p_eff),
		.top_idx   (top_idx),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.q_pop     (q_pop),
		.load_ok   (load_ok),
		.load      (load),
		.snap      (snap)
	);

	rsp_unload #(
		.MAX_PARITY (MAX_PARITY),
		.PW         (PW),
		.IW         (IW)
	) u_unload (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.snap        (snap),
		.p_eff       (p_eff),
		.top_idx     (top_idx),
		.load_ok     (load_ok),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.parity_byte (parity_byte),
		.last_parity (last_parity)
	);

	// No word may enter the LFSR before the generator is complete.
	a_no_take_without_gen: assert property (@(posedge clk) disable iff (!arst_n)
		!gen_ready |-> !q_pop)
		else $error("word consumed before generator was ready");

	// A parity run is never cut short: after a non-final parity word another follows.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_parity) |=> out_valid)
		else $error("parity run ended early");

	// A configuration write always forces a generator rebuild.
	a_cfg_rebuilds: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !gen_ready)
		else $error("generator still marked ready after configuration write");

endmodule

@@ bench/rs_parity_monitor.sv @@
// Scoreboard for reed_solomon_parity_encoder_core: mirrors the parity-count register and runs
// its own GF(2^8) LFSR on every accepted message word, then checks each parity word in order.
// Depends on rsp_pkg for the port widths, the reset parity count and the field constant.
`timescale 1ns / 1ps

module rs_parity_monitor #(
	parameter int MAX_PARITY = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rsp_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [rsp_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        last_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [rsp_pkg::BYTE_W-1:0]  parity_byte,
	input  logic                        last_parity,
	output int                          mismatches,
	output int                          pending_parity,
	output int                          words_seen,
	output int                          parity_seen
);

	typedef logic [rsp_pkg::BYTE_W-1:0] gf_t;

	typedef struct packed {
		gf_t  value;
		logic tail;
	} parity_word_t;

	localparam gf_t ALPHA = 8'h02;

	logic [rsp_pkg::CFG_W-1:0] parity_setting;
	gf_t                       remainder [MAX_PARITY];
	gf_t                       gen_taps [MAX_PARITY];
	logic                      taps_valid;
	parity_word_t              parity_q [$];

	function automatic gf_t gf_times(input gf_t a, input gf_t b);
		gf_t acc;
		acc = '0;
		for (int k = rsp_pkg::BYTE_W - 1; k >= 0; k--) begin
			if (acc[rsp_pkg::BYTE_W-1]) begin
				acc = {acc[rsp_pkg::BYTE_W-2:0], 1'b0} ^ rsp_pkg::GF_REDUCE;
			end else begin
				acc = {acc[rsp_pkg::BYTE_W-2:0], 1'b0};
			end
			if (b[k]) begin
				acc = acc ^ a;
			end
		end
		return acc;
	endfunction

	function automatic int active_parity();
		if (parity_setting == '0) begin
			return 1;
		end
		if (parity_setting > MAX_PARITY) begin
			return MAX_PARITY;
		end
		return int'(parity_setting);
	endfunction

	function automatic void clear_remainder();
		for (int j = 0; j < MAX_PARITY; j++) begin
			remainder[j] = '0;
		end
	endfunction

	// Multiplies out (x + alpha^i) for every root and keeps the non-leading
	// coefficients, highest degree first.
	function automatic void build_taps();
		gf_t poly [MAX_PARITY+1];
		gf_t root;
		int  p;
		p = active_parity();
		for (int k = 0; k <= MAX_PARITY; k++) begin
			poly[k] = '0;
		end
		poly[0] = rsp_pkg::GF_ONE;
		root = rsp_pkg::GF_ONE;
		for (int i = 0; i < p; i++) begin
			for (int k = i + 1; k > 0; k--) begin
				poly[k] = poly[k-1] ^ gf_times(root, poly[k]);
			end
			poly[0] = gf_times(root, poly[0]);
			root = gf_times(root, ALPHA);
		end
		for (int i = 0; i < MAX_PARITY; i++) begin
			if (i < p) begin
				gen_taps[i] = poly[p-1-i];
			end else begin
				gen_taps[i] = '0;
			end
		end
		taps_valid = 1'b1;
	endfunction

	function automatic void encode_word(input gf_t d, input logic l);
		gf_t          fb;
		int           p;
		parity_word_t w;
		if (!taps_valid) begin
			build_taps();
		end
		p = active_parity();
		fb = d ^ remainder[0];
		for (int j = 0; j < p - 1; j++) begin
			remainder[j] = remainder[j+1] ^ gf_times(fb, gen_taps[j]);
		end
		remainder[p-1] = gf_times(fb, gen_taps[p-1]);
		if (l) begin
			for (int j = 0; j < p; j++) begin
				w.value = remainder[j];
				w.tail = (j == p - 1);
				parity_q.push_back(w);
			end
			clear_remainder();
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t: parity check error: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		parity_word_t exp_w;
		if (!arst_n) begin
			parity_setting = rsp_pkg::PARITY_RESET;
			taps_valid = 1'b0;
			clear_remainder();
			parity_q.delete();
			pending_parity <= 0;
		end else begin
			if (cfg_we) begin
				parity_setting = cfg_wdata;
				taps_valid = 1'b0;
				clear_remainder();
			end
			if (in_valid && in_ready) begin
				words_seen++;
				encode_word(data_byte, last_data);
			end
			if (out_valid && out_ready) begin
				parity_seen++;
				if (parity_q.size() == 0) begin
					report_mismatch($sformatf("unexpected parity word %02h", parity_byte));
				end else begin
					exp_w = parity_q.pop_front();
					if (parity_byte !== exp_w.value) begin
						report_mismatch($sformatf("parity_byte %02h, expected %02h",
							parity_byte, exp_w.value));
					end
					if (last_parity !== exp_w.tail) begin
						report_mismatch($sformatf("last_parity %b, expected %b",
							last_parity, exp_w.tail));
					end
				end
			end
			pending_parity <= parity_q.size();
		end
	end

endmodule

@@ bench/reed_solomon_parity_encoder_core_tb.sv @@
// Testbench top for reed_solomon_parity_encoder_core: resets the encoder, writes parity counts
// while idle, streams message words with random gaps and stalls the parity side at random.
// Depends on rsp_pkg, the encoder RTL and rs_parity_monitor, which checks every parity word.
`timescale 1ns / 1ps

module reed_solomon_parity_encoder_core_tb;

	localparam int MAX_PARITY = 32;
	localparam int RANDOM_WORDS = 190;
	localparam int HOLD_CYCLES = 120;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [rsp_pkg::CFG_W-1:0]   cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	logic [rsp_pkg::BYTE_W-1:0]  data_byte;
	logic                        last_data;
	logic                        out_valid;
	logic                        out_ready;
	logic [rsp_pkg::BYTE_W-1:0]  parity_byte;
	logic                        last_parity;

	int mismatches;
	int pending_parity;
	int words_seen;
	int parity_seen;
	int words_sent = 0;
	int messages_sent = 0;
	int settings_used = 1;
	bit in_burst = 1'b0;
	bit out_burst = 1'b0;

	always #1 clk = ~clk;

	reed_solomon_parity_encoder_core #(
		.MAX_PARITY(MAX_PARITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_data(last_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.parity_byte(parity_byte),
		.last_parity(last_parity)
	);

	rs_parity_monitor #(
		.MAX_PARITY(MAX_PARITY)
	) u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_data(last_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.parity_byte(parity_byte),
		.last_parity(last_parity),
		.mismatches(mismatches),
		.pending_parity(pending_parity),
		.words_seen(words_seen),
		.parity_seen(parity_seen)
	);

	initial begin : watchdog
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_word(input logic [rsp_pkg::BYTE_W-1:0] d, input logic l);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_data <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		if (l) begin
			messages_sent++;
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_parity != 0) @(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic write_parity(input logic [rsp_pkg::CFG_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin : parity_sink
		int stall;
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				out_burst = !out_burst;
			end
			stall = out_burst ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int len;
		int pick;
		int start_words;
		int phase_end;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		last_data <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset parity count, extreme byte values, one- and multi-word messages.
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(8'h80, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'hAA, 1'b1);
		write_parity(6'd1);
		send_word(8'hFF, 1'b0);
		send_word(8'h7E, 1'b1);
		write_parity(6'd32);
		send_word(8'h01, 1'b0);
		send_word(8'hFE, 1'b0);
		send_word(8'h00, 1'b1);
		// A count of zero acts as one; counts above the maximum saturate.
		write_parity(6'd0);
		send_word(8'hC3, 1'b1);
		write_parity(6'd63);
		send_word(8'h5A, 1'b0);
		send_word(8'hA5, 1'b1);
		write_parity(6'd33);
		send_word(8'h11, 1'b1);
		// A write in the middle of a message restarts it from an empty remainder.
		write_parity(6'd8);
		send_word(8'hDE, 1'b0);
		send_word(8'hAD, 1'b0);
		send_word(8'hBE, 1'b0);
		write_parity(6'd8);
		send_word(8'hEF, 1'b0);
		send_word(8'h00, 1'b1);

		start_words = words_sent;
		while (words_sent - start_words < RANDOM_WORDS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				write_parity(6'd32);
			end else if (pick == 1) begin
				write_parity(6'($urandom_range(0, 63)));
			end else begin
				write_parity(6'($urandom_range(1, 16)));
			end
			phase_end = words_sent + $urandom_range(15, 40);
			while (words_sent < phase_end) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				in_burst = ($urandom_range(0, 3) == 0);
				for (int i = 0; i < len; i++) begin
					send_word(8'($urandom_range(0, 255)), i == len - 1);
				end
			end
		end

		wait_idle();
		$display("Encoded %0d message words in %0d messages under %0d parity-count settings.",
			words_seen, messages_sent, settings_used);
		$display("Checked %0d parity words, %0d errors.", parity_seen, mismatches);
		if (mismatches == 0 && pending_parity == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ reed_solomon_parity_encoder_core.f @@
design/rsp_pkg.sv
design/rsp_fifo.sv
design/rsp_gen.sv
design/rsp_lfsr.sv
design/rsp_unload.sv
design/reed_solomon_parity_encoder_core.sv
bench/rs_parity_monitor.sv
bench/reed_solomon_parity_encoder_core_tb.sv
